// ----- sv/gjr_garch_variance_filter_defines.svh -----
`ifndef GJR_GARCH_VARIANCE_FILTER_DEFINES_SVH
`define GJR_GARCH_VARIANCE_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GJR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GJR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gjr_pkg.sv -----
package gjr_pkg;

    localparam int VAR_W    = 48;
    localparam int RES_W    = 32;
    localparam int COEF_W   = 32;
    localparam int COEF_N   = 6;
    localparam int ACC_W    = 54;
    localparam int PROD_W   = 64;
    localparam int HI_W     = 55;
    localparam int TERM_W   = 56;
    localparam int SPLIT    = 24;
    localparam int E2_SHIFT = 16;
    localparam int Q_SHIFT  = 6;
    localparam int STEP_W   = 4;
    localparam int CNT_W    = 5;
    localparam int N_STEPS  = 14;
    localparam int SEQ_LAST = 16;
    localparam int REG_W    = 3;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;

    localparam logic [REG_W-1:0] REG_OMEGA  = 3'd0;
    localparam logic [REG_W-1:0] REG_ALPHA1 = 3'd1;
    localparam logic [REG_W-1:0] REG_ALPHA2 = 3'd2;
    localparam logic [REG_W-1:0] REG_GAMMA1 = 3'd3;
    localparam logic [REG_W-1:0] REG_GAMMA2 = 3'd4;
    localparam logic [REG_W-1:0] REG_BETA1  = 3'd5;
    localparam logic [REG_W-1:0] REG_BETA2  = 3'd6;
    localparam logic [REG_W-1:0] REG_FLOOR  = 3'd7;

    localparam logic [2:0] CID_ALPHA1 = 3'd0;
    localparam logic [2:0] CID_ALPHA2 = 3'd1;
    localparam logic [2:0] CID_GAMMA1 = 3'd2;
    localparam logic [2:0] CID_GAMMA2 = 3'd3;
    localparam logic [2:0] CID_BETA1  = 3'd4;
    localparam logic [2:0] CID_BETA2  = 3'd5;

    typedef enum logic [1:0] {
        UOP_SQ,
        UOP_HI,
        UOP_LO
    } t_uop_kind;

    typedef struct packed {
        t_uop_kind  kind;
        logic       lag;
        logic       use_var;
        logic [2:0] cid;
    } t_uop;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              done;
    } t_seq_ctl;

    typedef logic [COEF_N-1:0][COEF_W-1:0] t_coef_arr;
    typedef logic [1:0][RES_W-1:0]         t_res_pair;
    typedef logic [1:0][VAR_W-1:0]         t_var_pair;

    // two squares, then a high and a low pass for each of the six coefficients
    function automatic t_uop step_uop(logic [STEP_W-1:0] step);
        t_uop              u;
        logic [STEP_W-1:0] k;
        k         = step - STEP_W'(2);
        u.lag     = 1'b0;
        u.use_var = 1'b0;
        u.cid     = CID_ALPHA1;
        if (step < STEP_W'(2)) begin
            u.kind = UOP_SQ;
            u.lag  = step[0];
        end else begin
            u.kind = k[0] ? UOP_LO : UOP_HI;
            case (k[3:1])
                3'd0: begin
                    u.cid = CID_ALPHA1;
                end
                3'd1: begin
                    u.cid = CID_GAMMA1;
                end
                3'd2: begin
                    u.cid = CID_ALPHA2;
                    u.lag = 1'b1;
                end
                3'd3: begin
                    u.cid = CID_GAMMA2;
                    u.lag = 1'b1;
                end
                3'd4: begin
                    u.cid     = CID_BETA1;
                    u.use_var = 1'b1;
                end
                3'd5: begin
                    u.cid     = CID_BETA2;
                    u.lag     = 1'b1;
                    u.use_var = 1'b1;
                end
                default: begin
                    u.cid = CID_ALPHA1;
                end
            endcase
        end
        return u;
    endfunction

endpackage

// ----- sv/gjr_garch_variance_filter.sv -----
// Channel  Direction  Handshake                  Payload
// in       in         i_in_valid / o_in_stall    i_residual, i_use_seed, i_seed_variance
// out      out        o_out_valid / i_out_stall  o_variance, o_floored
// config   in         psel, penable, pwrite      paddr, pwdata -> prdata (8-byte stride)
//
// Computed word: the time from acceptance to the next acceptance is set by fourteen
// passes through the one 32x32 multiplier plus a three-stage drain into the accumulator.
// Output register frees the input side while a result waits.
// Synchronous active-low reset clears control, registers to their defaults, histories.
// A stalled output holds the result; the next word may be taken meanwhile.
module gjr_garch_variance_filter #(
    parameter int ARCH_LAGS  = 2,
    parameter int GARCH_LAGS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [gjr_pkg::RES_W-1:0]    i_residual,
    input  logic                                i_use_seed,
    input  logic [gjr_pkg::VAR_W-1:0]           i_seed_variance,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [gjr_pkg::VAR_W-1:0]           o_variance,
    output logic                                o_floored,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gjr_pkg::ADDR_W-1:0]          paddr,
    input  logic [gjr_pkg::DATA_W-1:0]          pwdata,
    output logic [gjr_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_state;

    t_state                                     r_state;
    logic [gjr_pkg::VAR_W-1:0]                  r_omega;
    logic [gjr_pkg::VAR_W-1:0]                  r_floor;
    gjr_pkg::t_coef_arr                         r_coef;
    logic [ARCH_LAGS-1:0][gjr_pkg::RES_W-1:0]   r_res_hist;
    logic [GARCH_LAGS-1:0][gjr_pkg::VAR_W-1:0]  r_var_hist;
    logic [gjr_pkg::RES_W-1:0]                  r_cur_res;
    logic [gjr_pkg::VAR_W-1:0]                  r_res_var;
    logic                                       r_res_flo;
    logic                                       r_out_vld;
    logic [gjr_pkg::VAR_W-1:0]                  r_variance;
    logic                                       r_floored;

    logic [gjr_pkg::REG_W-1:0]                  w_idx;
    logic                                       w_wr;
    logic                                       w_start;
    logic                                       w_out_free;
    gjr_pkg::t_seq_ctl                          w_ctl;
    gjr_pkg::t_res_pair                         w_e;
    gjr_pkg::t_var_pair                         w_h;
    logic signed [gjr_pkg::ACC_W-1:0]           w_acc;
    logic                                       w_upper;
    logic                                       w_flo;
    logic [gjr_pkg::VAR_W-1:0]                  w_fin_var;
    logic                                       w_push;
    logic [gjr_pkg::RES_W-1:0]                  w_push_res;
    logic [gjr_pkg::VAR_W-1:0]                  w_push_var;

    assign w_idx      = paddr[gjr_pkg::ADDR_W-1:gjr_pkg::ADDR_W-gjr_pkg::REG_W];
    assign w_wr       = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_start    = (r_state == S_IDLE) && i_in_valid && !i_use_seed;
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        unique case (w_idx) inside
            gjr_pkg::REG_OMEGA: prdata = gjr_pkg::DATA_W'(r_omega);
            gjr_pkg::REG_FLOOR: prdata = gjr_pkg::DATA_W'(r_floor);
            gjr_pkg::REG_ALPHA1, gjr_pkg::REG_ALPHA2, gjr_pkg::REG_GAMMA1,
            gjr_pkg::REG_GAMMA2, gjr_pkg::REG_BETA1, gjr_pkg::REG_BETA2:
                prdata = gjr_pkg::DATA_W'(r_coef[3'(w_idx - 3'd1)]);
            default: prdata = '0;
        endcase
    end

    assign w_e[0] = r_res_hist[0];
    assign w_e[1] = (ARCH_LAGS > 1) ? r_res_hist[ARCH_LAGS-1] : '0;
    assign w_h[0] = r_var_hist[0];
    assign w_h[1] = (GARCH_LAGS > 1) ? r_var_hist[GARCH_LAGS-1] : '0;

    gjr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .o_ctl   (w_ctl)
    );

    gjr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_omega (r_omega),
        .i_coef  (r_coef),
        .i_e     (w_e),
        .i_h     (w_h),
        .o_acc   (w_acc)
    );

    // floor check: negative, below floor, or past 48 bits
    always_comb begin
        w_upper   = |w_acc[gjr_pkg::ACC_W-2:gjr_pkg::VAR_W];
        w_flo     = w_acc[gjr_pkg::ACC_W-1] || w_upper
                    || (w_acc[gjr_pkg::VAR_W-1:0] < r_floor);
        w_fin_var = w_flo ? r_floor : w_acc[gjr_pkg::VAR_W-1:0];
    end

    always_comb begin
        w_push     = 1'b0;
        w_push_res = r_cur_res;
        w_push_var = w_fin_var;
        if (r_state == S_IDLE && i_in_valid && i_use_seed) begin
            w_push     = 1'b1;
            w_push_res = i_residual;
            w_push_var = i_seed_variance;
        end else if (r_state == S_CALC && w_ctl.done) begin
            w_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_hist <= '0;
            r_var_hist <= '0;
        end else if (w_push) begin
            r_res_hist[0] <= w_push_res;
            r_var_hist[0] <= w_push_var;
            for (int i = 1; i < ARCH_LAGS; i++) begin
                r_res_hist[i] <= r_res_hist[i-1];
            end
            for (int i = 1; i < GARCH_LAGS; i++) begin
                r_var_hist[i] <= r_var_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_omega   <= '0;
            r_floor   <= gjr_pkg::VAR_W'(1);
            r_coef    <= '0;
        end else begin
            if (w_wr) begin
                unique case (w_idx) inside
                    gjr_pkg::REG_OMEGA: r_omega <= pwdata[gjr_pkg::VAR_W-1:0];
                    gjr_pkg::REG_FLOOR: r_floor <= pwdata[gjr_pkg::VAR_W-1:0];
                    gjr_pkg::REG_ALPHA1, gjr_pkg::REG_ALPHA2, gjr_pkg::REG_GAMMA1,
                    gjr_pkg::REG_GAMMA2, gjr_pkg::REG_BETA1, gjr_pkg::REG_BETA2:
                        r_coef[3'(w_idx - 3'd1)] <= pwdata[gjr_pkg::COEF_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_vld && !i_out_stall && r_state != S_HOLD) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_use_seed) begin
                            r_res_var <= i_seed_variance;
                            r_res_flo <= 1'b0;
                            r_state   <= S_HOLD;
                        end else begin
                            r_cur_res <= i_residual;
                            r_state   <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (w_ctl.done) begin
                        r_res_var <= w_fin_var;
                        r_res_flo <= w_flo;
                        r_state   <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_variance <= r_res_var;
                        r_floored  <= r_res_flo;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_variance  = r_variance;
    assign o_floored   = r_floored;

`include "gjr_garch_variance_filter_defines.svh"

    `GJR_ASSERT_NOW(a_done_in_calc, w_ctl.done, r_state == S_CALC, "sequencer done outside calc")
    `GJR_ASSERT_NEXT(a_start_runs, w_start, r_state == S_CALC && !w_ctl.done,
        "computed word did not start the sequencer")
    `GJR_ASSERT_NOW(a_quiet_when_idle, r_state != S_CALC, !w_ctl.issue && !w_ctl.done,
        "multiplier issued outside calc")

endmodule

// ----- sv/gjr_seq.sv -----
module gjr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output gjr_pkg::t_seq_ctl   o_ctl
);

    logic                       r_busy;
    logic [gjr_pkg::CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == gjr_pkg::CNT_W'(gjr_pkg::SEQ_LAST)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + gjr_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_ctl.load  = i_start;
        o_ctl.issue = r_busy && (r_cnt < gjr_pkg::CNT_W'(gjr_pkg::N_STEPS));
        o_ctl.step  = r_cnt[gjr_pkg::STEP_W-1:0];
        o_ctl.done  = r_busy && (r_cnt == gjr_pkg::CNT_W'(gjr_pkg::SEQ_LAST));
    end

endmodule

// ----- sv/gjr_mac.sv -----
module gjr_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gjr_pkg::t_seq_ctl                    i_ctl,
    input  logic [gjr_pkg::VAR_W-1:0]            i_omega,
    input  gjr_pkg::t_coef_arr                   i_coef,
    input  gjr_pkg::t_res_pair                   i_e,
    input  gjr_pkg::t_var_pair                   i_h,
    output logic signed [gjr_pkg::ACC_W-1:0]     o_acc
);

    gjr_pkg::t_uop                      w_uop;
    logic [gjr_pkg::COEF_W-1:0]         w_coef;
    logic [gjr_pkg::COEF_W-1:0]         w_coef_mag;
    logic [gjr_pkg::RES_W-1:0]          w_e;
    logic [gjr_pkg::RES_W-1:0]          w_e_mag;
    logic                               w_gate;
    logic [gjr_pkg::VAR_W-1:0]          w_x;
    logic [31:0]                        w_op_a;
    logic [31:0]                        w_op_b;
    logic [gjr_pkg::PROD_W-1:0]         w_prod;
    logic [gjr_pkg::ACC_W-1:0]          w_q;

    logic [gjr_pkg::PROD_W-1:0]         r_prod;
    logic                               r_p_vld;
    gjr_pkg::t_uop_kind                 r_p_kind;
    logic                               r_p_lag;
    logic                               r_p_neg;
    logic [1:0][gjr_pkg::VAR_W-1:0]     r_e2;
    logic [gjr_pkg::HI_W-1:0]           r_hi;
    logic [gjr_pkg::TERM_W-1:0]         r_term;
    logic                               r_t_vld;
    logic                               r_t_neg;
    logic signed [gjr_pkg::ACC_W-1:0]   r_acc;

    always_comb begin
        w_uop      = gjr_pkg::step_uop(i_ctl.step);
        w_coef     = i_coef[w_uop.cid];
        w_e        = i_e[w_uop.lag];
        w_e_mag    = w_e[gjr_pkg::RES_W-1] ? (~w_e + 1'b1) : w_e;
        // gamma only counts for a negative residual
        w_gate     = (w_uop.cid == gjr_pkg::CID_GAMMA1 || w_uop.cid == gjr_pkg::CID_GAMMA2)
                     && !w_e[gjr_pkg::RES_W-1];
        w_coef_mag = w_gate ? '0
                   : (w_coef[gjr_pkg::COEF_W-1] ? (~w_coef + 1'b1) : w_coef);
        w_x        = w_uop.use_var ? i_h[w_uop.lag] : r_e2[w_uop.lag];
        case (w_uop.kind)
            gjr_pkg::UOP_SQ: begin
                w_op_a = w_e_mag;
                w_op_b = w_e_mag;
            end
            gjr_pkg::UOP_HI: begin
                w_op_a = w_coef_mag;
                w_op_b = 32'(w_x[gjr_pkg::VAR_W-1:gjr_pkg::SPLIT]);
            end
            default: begin
                w_op_a = w_coef_mag;
                w_op_b = 32'(w_x[gjr_pkg::SPLIT-1:0]);
            end
        endcase
        w_prod = w_op_a * w_op_b;
        w_q    = gjr_pkg::ACC_W'(r_term[gjr_pkg::TERM_W-1:gjr_pkg::Q_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_t_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.issue;
            r_t_vld <= r_p_vld && (r_p_kind == gjr_pkg::UOP_LO) && !i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_p_kind <= w_uop.kind;
        r_p_lag  <= w_uop.lag;
        r_p_neg  <= w_coef[gjr_pkg::COEF_W-1];
        r_t_neg  <= r_p_neg;
        r_term   <= gjr_pkg::TERM_W'(r_hi)
                  + gjr_pkg::TERM_W'(r_prod[gjr_pkg::HI_W:gjr_pkg::SPLIT]);
        if (r_p_vld) begin
            case (r_p_kind)
                gjr_pkg::UOP_SQ: begin
                    r_e2[r_p_lag] <= r_prod[gjr_pkg::PROD_W-1:gjr_pkg::E2_SHIFT];
                end
                gjr_pkg::UOP_HI: begin
                    r_hi <= r_prod[gjr_pkg::HI_W-1:0];
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.load) begin
            r_acc <= $signed(gjr_pkg::ACC_W'(i_omega));
        end else if (r_t_vld) begin
            r_acc <= r_t_neg ? (r_acc - $signed(w_q)) : (r_acc + $signed(w_q));
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- verif/tb_gjr_garch_variance_filter.sv -----
module tb_gjr_garch_variance_filter;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [gjr_pkg::VAR_W-1:0] variance;
        logic                      floored;
    } t_variance_word;

    // mirrors the register file and the lag histories, predicts one variance per word
    class variance_tracker;
        logic [63:0]               regs_q [8];
        logic [gjr_pkg::RES_W-1:0] res_hist [2];
        logic [gjr_pkg::VAR_W-1:0] var_hist [2];
        t_variance_word            expected_q [$];
        int                        n_words;
        int                        n_seed;
        int                        n_floored;
        int                        n_checked;
        int                        n_errors;

        function new();
            for (int i = 0; i < 8; i++) begin
                regs_q[i] = '0;
            end
            regs_q[gjr_pkg::REG_FLOOR] = 64'd1;
            for (int i = 0; i < 2; i++) begin
                res_hist[i] = '0;
                var_hist[i] = '0;
            end
            n_words   = 0;
            n_seed    = 0;
            n_floored = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void set_reg(logic [gjr_pkg::REG_W-1:0] idx, logic [63:0] val);
            if (idx == gjr_pkg::REG_OMEGA || idx == gjr_pkg::REG_FLOOR) begin
                regs_q[idx] = {16'd0, val[47:0]};
            end else begin
                regs_q[idx] = {32'd0, val[31:0]};
            end
        endfunction

        // Q2.30 coefficient times Q16.32 value, magnitude truncated then signed
        function longint scaled(logic [63:0] coef_raw, logic [gjr_pkg::VAR_W-1:0] x);
            longint      c;
            logic [63:0] mag;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] r;
            c   = longint'(signed'(coef_raw[31:0]));
            mag = (c < 0) ? -c : c;
            a   = mag * {40'd0, x[47:24]};
            b   = mag * {40'd0, x[23:0]};
            r   = (a + (b >> 24)) >> 6;
            return (c < 0) ? -longint'(r) : longint'(r);
        endfunction

        function logic [gjr_pkg::VAR_W-1:0] squared(logic [gjr_pkg::RES_W-1:0] raw);
            longint      e;
            logic [63:0] m;
            e = longint'(signed'(raw));
            m = (e < 0) ? -e : e;
            m = (m * m) >> 16;
            return m[47:0];
        endfunction

        function void take_input(logic [gjr_pkg::RES_W-1:0] res, logic seed,
                                 logic [gjr_pkg::VAR_W-1:0] sv);
            longint                    s;
            logic [gjr_pkg::VAR_W-1:0] e2;
            t_variance_word            w;
            w.floored = 1'b0;
            if (seed) begin
                w.variance = sv;
                n_seed++;
            end else begin
                s = longint'(regs_q[gjr_pkg::REG_OMEGA]);
                for (int j = 0; j < 2; j++) begin
                    e2 = squared(res_hist[j]);
                    s += scaled(regs_q[gjr_pkg::REG_ALPHA1 + j], e2);
                    if (res_hist[j][gjr_pkg::RES_W-1]) begin
                        s += scaled(regs_q[gjr_pkg::REG_GAMMA1 + j], e2);
                    end
                end
                for (int j = 0; j < 2; j++) begin
                    s += scaled(regs_q[gjr_pkg::REG_BETA1 + j], var_hist[j]);
                end
                if (s < longint'(regs_q[gjr_pkg::REG_FLOOR])
                    || s > 64'sh0000_FFFF_FFFF_FFFF) begin
                    w.variance = regs_q[gjr_pkg::REG_FLOOR][47:0];
                    w.floored  = 1'b1;
                    n_floored++;
                end else begin
                    w.variance = s[47:0];
                end
            end
            res_hist[1] = res_hist[0];
            res_hist[0] = res;
            var_hist[1] = var_hist[0];
            var_hist[0] = w.variance;
            expected_q.push_back(w);
            n_words++;
        endfunction

        function void check_variance(logic [gjr_pkg::VAR_W-1:0] v, logic fl);
            t_variance_word w;
            n_checked++;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word, variance %h floored %b", $time, v, fl);
            end else begin
                w = expected_q.pop_front();
                if (v !== w.variance) begin
                    n_errors++;
                    $display("%0t: variance expected %h actual %h", $time, w.variance, v);
                end
                if (fl !== w.floored) begin
                    n_errors++;
                    $display("%0t: floored expected %b actual %b", $time, w.floored, fl);
                end
            end
        endfunction
    endclass

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic [gjr_pkg::RES_W-1:0]     i_residual      = '0;
    logic                          i_use_seed      = 1'b0;
    logic [gjr_pkg::VAR_W-1:0]     i_seed_variance = '0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic [gjr_pkg::VAR_W-1:0]     o_variance;
    logic                          o_floored;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [gjr_pkg::ADDR_W-1:0]    paddr           = '0;
    logic [gjr_pkg::DATA_W-1:0]    pwdata          = '0;
    logic [gjr_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    variance_tracker tracker;
    logic            quiet_run  = 1'b0;
    int              n_settings = 1;

    gjr_garch_variance_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_residual      (i_residual),
        .i_use_seed      (i_use_seed),
        .i_seed_variance (i_seed_variance),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_variance      (o_variance),
        .o_floored       (o_floored),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall = !quiet_run && ($urandom_range(99) < 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_variance(o_variance, o_floored);
        end
    end

    function automatic logic [gjr_pkg::VAR_W-1:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[47:0];
    endfunction

    // entered and left at a falling edge
    task automatic write_reg(input logic [gjr_pkg::REG_W-1:0] idx, input logic [63:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = gjr_pkg::ADDR_W'({idx, 3'b000});
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_settings(input logic [63:0] omega, input logic [63:0] a1,
                                 input logic [63:0] a2, input logic [63:0] g1,
                                 input logic [63:0] g2, input logic [63:0] b1,
                                 input logic [63:0] b2, input logic [63:0] vfloor);
        write_reg(gjr_pkg::REG_OMEGA, omega);
        write_reg(gjr_pkg::REG_ALPHA1, a1);
        write_reg(gjr_pkg::REG_ALPHA2, a2);
        write_reg(gjr_pkg::REG_GAMMA1, g1);
        write_reg(gjr_pkg::REG_GAMMA2, g2);
        write_reg(gjr_pkg::REG_BETA1, b1);
        write_reg(gjr_pkg::REG_BETA2, b2);
        write_reg(gjr_pkg::REG_FLOOR, vfloor);
        n_settings++;
    endtask

    task automatic load_random_settings(input int mode);
        logic [63:0] c [6];
        logic [63:0] omega;
        logic [63:0] vfloor;
        if (mode == 0) begin
            // typical stationary fit
            omega  = 64'($urandom_range(16777216));
            c[0]   = 64'($urandom_range(322122547));
            c[1]   = 64'($urandom_range(161061273));
            c[2]   = 64'($urandom_range(322122547));
            c[3]   = 64'($urandom_range(161061273));
            c[4]   = 64'($urandom_range(912680550));
            c[5]   = 64'($urandom_range(107374182));
            vfloor = 64'($urandom_range(65536));
        end else if (mode == 1) begin
            omega  = 64'(rand48());
            for (int i = 0; i < 6; i++) begin
                c[i] = 64'($urandom());
            end
            vfloor = 64'(rand48() >> $urandom_range(47));
        end else begin
            omega  = 64'(48'($urandom()) << 4);
            for (int i = 0; i < 6; i++) begin
                c[i] = 64'(32'($urandom_range(1073741824)) - 32'd536870912);
            end
            vfloor = $urandom_range(1) ? 64'd0 : 64'($urandom());
        end
        load_settings(omega, c[0], c[1], c[2], c[3], c[4], c[5], vfloor);
    endtask

    // entered and left at a falling edge; valid is left high for the next word
    task automatic send_word(input logic [gjr_pkg::RES_W-1:0] res, input logic seed,
                             input logic [gjr_pkg::VAR_W-1:0] sv);
        while (!quiet_run && $urandom_range(99) < 15) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_residual      = res;
        i_use_seed      = seed;
        i_seed_variance = sv;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        tracker.take_input(res, seed, sv);
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        i_in_valid = 1'b0;
        while (tracker.expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_random_words(input int n);
        logic [gjr_pkg::RES_W-1:0] res;
        logic [gjr_pkg::VAR_W-1:0] sv;
        logic                      seed;
        int                        rk;
        for (int k = 0; k < n; k++) begin
            rk   = $urandom_range(9);
            seed = ($urandom_range(99) < 10);
            sv   = $urandom_range(1) ? rand48() : 48'($urandom());
            if (rk <= 5) begin
                res = 32'($urandom_range(67108864)) - 32'd33554432;
            end else if (rk <= 7) begin
                res = $urandom();
            end else if (rk == 8) begin
                res = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                res = '0;
            end
            send_word(res, seed, sv);
        end
    endtask

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: zero sum against a floor of one
        send_word(32'h8000_0000, 1'b0, 48'h0);
        send_word(32'h7FFF_FFFF, 1'b1, 48'h0);
        send_word(32'hFFFF_FFFF, 1'b0, 48'h0);
        drain_words();

        // largest weights on saturated history: overflow
        load_settings(64'd0, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                      64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'd0);
        send_word(32'h8000_0000, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_word(32'h8000_0000, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_word(32'h7FFF_FFFF, 1'b0, 48'h0);
        send_word(32'h0000_0000, 1'b0, 48'h0);
        drain_words();

        // most negative weights: negative sum under the top floor
        load_settings(64'hFFFF_FFFF_FFFF, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000,
                      64'h8000_0000, 64'h8000_0000, 64'h8000_0000, 64'hFFFF_FFFF_FFFF);
        send_word(32'h7FFF_FFFF, 1'b1, 48'h0);
        send_word(32'h8000_0000, 1'b0, 48'h0);
        send_word(32'h0000_0000, 1'b0, 48'h0);
        drain_words();

        // sum lands exactly on the floor
        load_settings(64'h1234_5678, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                      64'h1234_5678);
        send_word(32'h8000_0000, 1'b0, 48'h0);
        send_word(32'h7FFF_FFFF, 1'b0, 48'h0);
        drain_words();

        // typical fit through warm-up and residual extremes
        load_settings(64'd429497, 64'd107374182, 64'd53687091, 64'd85899346,
                      64'd42949673, 64'd751619276, 64'd53687091, 64'd4295);
        send_word(32'h0100_0000, 1'b1, 48'h1_0000_0000);
        send_word(32'hFF00_0000, 1'b1, 48'h1_0000_0000);
        send_word(32'h8000_0000, 1'b0, 48'h0);
        send_word(32'h7FFF_FFFF, 1'b0, 48'h0);
        send_word(32'h0000_0000, 1'b0, 48'h0);
        send_word(32'hFFFF_FFFF, 1'b0, 48'h0);
        send_word(32'h0000_0001, 1'b0, 48'h0);
        send_word(32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_word(32'h0080_0000, 1'b0, 48'h0);
        send_word(32'h8000_0000, 1'b0, 48'h0);
        drain_words();

        quiet_run = 1'b1;
        load_random_settings(0);
        send_random_words(175);
        drain_words();
        quiet_run = 1'b0;

        load_random_settings(0);
        send_random_words(175);
        drain_words();
        load_random_settings(1);
        send_random_words(175);
        drain_words();
        load_random_settings(2);
        send_random_words(175);
        drain_words();
        load_random_settings(0);
        send_random_words(175);
        drain_words();
        load_random_settings(2);
        send_random_words(175);
        drain_words();
        load_random_settings(0);
        send_random_words(175);
        drain_words();

        repeat (30) @(negedge i_clk);
        $display("covered %0d words (%0d seeded, %0d floored) over %0d register settings",
                 tracker.n_words, tracker.n_seed, tracker.n_floored, n_settings);
        $display("checked %0d result words, %0d mismatches",
                 tracker.n_checked, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
